FILE: hdl/stack_bytecode_machine_macros.svh
// Assertion macros used by the top-level file that checks this block.
`ifndef STACK_BYTECODE_MACHINE_MACROS_SVH
`define STACK_BYTECODE_MACHINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sbm_pkg.sv
package sbm_pkg;

    localparam int MEM_WORDS = 16384;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_EXEC   = 2'd1;
    localparam logic [1:0] REQ_SETACC = 2'd2;

    localparam logic [2:0] ST_RUN  = 3'd0;
    localparam logic [2:0] ST_EXIT = 3'd1;
    localparam logic [2:0] ST_SYS  = 3'd2;
    localparam logic [2:0] ST_UNK  = 3'd3;
    localparam logic [2:0] ST_DIVZ = 3'd4;

    localparam logic [5:0] OP_LEA  = 6'd0;
    localparam logic [5:0] OP_IMM  = 6'd1;
    localparam logic [5:0] OP_JMP  = 6'd2;
    localparam logic [5:0] OP_CALL = 6'd3;
    localparam logic [5:0] OP_JZ   = 6'd4;
    localparam logic [5:0] OP_JNZ  = 6'd5;
    localparam logic [5:0] OP_ENT  = 6'd6;
    localparam logic [5:0] OP_ADJ  = 6'd7;
    localparam logic [5:0] OP_LEV  = 6'd8;
    localparam logic [5:0] OP_LI   = 6'd9;
    localparam logic [5:0] OP_LC   = 6'd10;
    localparam logic [5:0] OP_SI   = 6'd11;
    localparam logic [5:0] OP_SC   = 6'd12;
    localparam logic [5:0] OP_PUSH = 6'd13;
    localparam logic [5:0] OP_OR   = 6'd14;
    localparam logic [5:0] OP_XOR  = 6'd15;
    localparam logic [5:0] OP_AND  = 6'd16;
    localparam logic [5:0] OP_EQ   = 6'd17;
    localparam logic [5:0] OP_NE   = 6'd18;
    localparam logic [5:0] OP_LT   = 6'd19;
    localparam logic [5:0] OP_GT   = 6'd20;
    localparam logic [5:0] OP_LE   = 6'd21;
    localparam logic [5:0] OP_GE   = 6'd22;
    localparam logic [5:0] OP_SHL  = 6'd23;
    localparam logic [5:0] OP_SHR  = 6'd24;
    localparam logic [5:0] OP_ADD  = 6'd25;
    localparam logic [5:0] OP_SUB  = 6'd26;
    localparam logic [5:0] OP_MUL  = 6'd27;
    localparam logic [5:0] OP_DIV  = 6'd28;
    localparam logic [5:0] OP_MOD  = 6'd29;
    localparam logic [5:0] OP_SYS_FIRST = 6'd30;
    localparam logic [5:0] OP_SYS_LAST  = 6'd36;
    localparam logic [5:0] OP_EXIT = 6'd37;

    localparam logic [16:0] SP_TOP = 17'h10000;

    typedef enum logic [2:0] {
        ADDR_PC, ADDR_SP, ADDR_SPM4, ADDR_BP, ADDR_ACC, ADDR_TMP, ADDR_IN
    } addr_sel_t;

    typedef enum logic [2:0] {
        WD_IN, WD_ACC, WD_PC, WD_BP, WD_BYTE
    } wd_sel_t;

    typedef enum logic [1:0] {
        PC_KEEP, PC_INC, PC_TGT
    } pc_op_t;

    typedef enum logic [2:0] {
        SP_KEEP, SP_INC, SP_DEC, SP_BP, SP_ENT, SP_ADJ
    } sp_op_t;

    typedef enum logic [1:0] {
        BP_KEEP, BP_SPM4, BP_RD
    } bp_op_t;

    typedef enum logic [2:0] {
        ACC_KEEP, ACC_RD, ACC_IN, ACC_LEA, ACC_BYTE, ACC_ALU, ACC_DIV
    } acc_op_t;

    typedef struct packed {
        logic      in_ld;
        addr_sel_t addr_sel;
        logic      mem_we;
        wd_sel_t   wd_sel;
        pc_op_t    pc_op;
        sp_op_t    sp_op;
        bp_op_t    bp_op;
        acc_op_t   acc_op;
        logic      op_ld;
        logic      tmp_ld;
        logic      div_start;
        logic      sys_ld;
        logic      halt_ld;
        logic [2:0] halt_code;
        logic      halt_rd;
        logic      out_ld;
    } sbm_cmd_t;

    typedef struct packed {
        logic [5:0] op;
        logic       op_known;
        logic       acc_zero;
        logic       halted;
        logic       div_busy;
        logic       div_done;
    } sbm_stat_t;

endpackage

FILE: hdl/sbm_req_if.sv
interface sbm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [15:0]        address;
    logic signed [31:0] value;

    modport source (output valid, output req_type, output address, output value, input ready);
    modport sink   (input valid, input req_type, input address, input value, output ready);
endinterface

FILE: hdl/sbm_rsp_if.sv
interface sbm_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [15:0]        pc_now;
    logic signed [31:0] acc_now;
    logic [16:0]        sp_now;
    logic [5:0]         call_code;
    logic signed [31:0] exit_value;

    modport source (output valid, output status, output pc_now, output acc_now,
                    output sp_now, output call_code, output exit_value, input ready);
    modport sink   (input valid, input status, input pc_now, input acc_now,
                    input sp_now, input call_code, input exit_value, output ready);
endinterface

FILE: hdl/sbm_div.sv
module sbm_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quot,
    output logic [31:0] rem
);
    import sbm_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_r_reg, neg_r_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        shifted    = {rem_reg, quo_reg[31]};
        diff       = shifted - {1'b0, den_reg};
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            quo_next   = dividend[31] ? -dividend : dividend;
            den_next   = divisor[31] ? -divisor : divisor;
            rem_next   = '0;
            neg_q_next = dividend[31] ^ divisor[31];
            neg_r_next = dividend[31];
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = neg_q_reg ? -quo_reg : quo_reg;
    assign rem  = neg_r_reg ? -rem_reg : rem_reg;
endmodule

FILE: hdl/sbm_datapath.sv
module sbm_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sbm_pkg::sbm_cmd_t cmd,
    output sbm_pkg::sbm_stat_t stat,
    input  logic [15:0]       in_address,
    input  logic [31:0]       in_value,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_data,
    output logic [2:0]        out_status,
    output logic [15:0]       out_pc,
    output logic [31:0]       out_acc,
    output logic [16:0]       out_sp,
    output logic [5:0]        out_code,
    output logic [31:0]       out_exit
);
    import sbm_pkg::*;

    logic [31:0] mem [MEM_WORDS];
    logic [31:0] rdata_reg;

    logic [15:0] pc_reg, pc_next;
    logic [16:0] sp_reg, sp_next;
    logic [16:0] bp_reg, bp_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] op_reg;
    logic [31:0] tmp_reg;
    logic [15:0] inaddr_reg;
    logic [31:0] inval_reg;
    logic        halted_reg;
    logic [2:0]  hstat_reg;
    logic [31:0] hval_reg;
    logic [2:0]  stat_reg;
    logic [5:0]  code_reg;

    logic [31:0] mem_addr;
    logic [31:0] wdata;
    logic [MEM_AW-1:0] idx;
    logic [16:0] sp_m4;
    logic [16:0] imm4;
    logic [31:0] alu;
    logic [7:0]  byte_rd;
    logic [4:0]  sh_in;
    logic [4:0]  sh_st;
    logic [31:0] merged;
    logic        div_busy;
    logic        div_done;
    logic [31:0] div_q;
    logic [31:0] div_r;

    sbm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (tmp_reg),
        .divisor  (acc_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    assign sp_m4 = sp_reg - 17'd4;
    assign imm4  = {rdata_reg[14:0], 2'b00};
    assign sh_in = {acc_reg[1:0], 3'b000};
    assign sh_st = {tmp_reg[1:0], 3'b000};

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_PC:   mem_addr = {16'd0, pc_reg};
            ADDR_SP:   mem_addr = {15'd0, sp_reg};
            ADDR_SPM4: mem_addr = {15'd0, sp_m4};
            ADDR_BP:   mem_addr = {15'd0, bp_reg};
            ADDR_ACC:  mem_addr = acc_reg;
            ADDR_TMP:  mem_addr = tmp_reg;
            ADDR_IN:   mem_addr = {16'd0, inaddr_reg};
            default:   mem_addr = {16'd0, pc_reg};
        endcase
    end

    assign idx     = mem_addr[MEM_AW+1:2];
    assign byte_rd = 8'(rdata_reg >> sh_in);
    assign merged  = (rdata_reg & ~(32'hFF << sh_st)) | ({24'd0, acc_reg[7:0]} << sh_st);

    always_comb
    begin
        case (cmd.wd_sel)
            WD_IN:   wdata = inval_reg;
            WD_ACC:  wdata = acc_reg;
            WD_PC:   wdata = {16'd0, pc_reg};
            WD_BP:   wdata = {15'd0, bp_reg};
            WD_BYTE: wdata = merged;
            default: wdata = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[idx] <= wdata;
        end
        rdata_reg <= mem[idx];
    end

    always_comb
    begin
        case (op_reg[5:0])
            OP_OR:   alu = tmp_reg | acc_reg;
            OP_XOR:  alu = tmp_reg ^ acc_reg;
            OP_AND:  alu = tmp_reg & acc_reg;
            OP_EQ:   alu = {31'd0, tmp_reg == acc_reg};
            OP_NE:   alu = {31'd0, tmp_reg != acc_reg};
            OP_LT:   alu = {31'd0, $signed(tmp_reg) < $signed(acc_reg)};
            OP_GT:   alu = {31'd0, $signed(tmp_reg) > $signed(acc_reg)};
            OP_LE:   alu = {31'd0, $signed(tmp_reg) <= $signed(acc_reg)};
            OP_GE:   alu = {31'd0, $signed(tmp_reg) >= $signed(acc_reg)};
            OP_SHL:  alu = tmp_reg << acc_reg[4:0];
            OP_SHR:  alu = $unsigned($signed(tmp_reg) >>> acc_reg[4:0]);
            OP_ADD:  alu = tmp_reg + acc_reg;
            OP_SUB:  alu = tmp_reg - acc_reg;
            OP_MUL:  alu = tmp_reg * acc_reg;
            default: alu = '0;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        case (cmd.pc_op)
            PC_INC:  pc_next = pc_reg + 16'd4;
            PC_TGT:  pc_next = {rdata_reg[15:2], 2'b00};
            default: pc_next = pc_reg;
        endcase
        if (cfg_we)
        begin
            pc_next = {cfg_data[15:2], 2'b00};
        end

        case (cmd.sp_op)
            SP_INC:  sp_next = sp_reg + 17'd4;
            SP_DEC:  sp_next = sp_m4;
            SP_BP:   sp_next = bp_reg;
            SP_ENT:  sp_next = sp_m4 - imm4;
            SP_ADJ:  sp_next = sp_reg + imm4;
            default: sp_next = sp_reg;
        endcase

        case (cmd.bp_op)
            BP_SPM4: bp_next = sp_m4;
            BP_RD:   bp_next = rdata_reg[16:0];
            default: bp_next = bp_reg;
        endcase

        case (cmd.acc_op)
            ACC_RD:   acc_next = rdata_reg;
            ACC_IN:   acc_next = inval_reg;
            ACC_LEA:  acc_next = {15'd0, bp_reg} + {rdata_reg[29:0], 2'b00};
            ACC_BYTE: acc_next = {{24{byte_rd[7]}}, byte_rd};
            ACC_ALU:  acc_next = alu;
            ACC_DIV:  acc_next = (op_reg[5:0] == OP_DIV) ? div_q : div_r;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= '0;
            sp_reg     <= SP_TOP;
            bp_reg     <= SP_TOP;
            acc_reg    <= '0;
            halted_reg <= 1'b0;
            hstat_reg  <= ST_RUN;
            hval_reg   <= '0;
            stat_reg   <= ST_RUN;
            code_reg   <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            sp_reg  <= sp_next;
            bp_reg  <= bp_next;
            acc_reg <= acc_next;
            if (cmd.in_ld)
            begin
                stat_reg <= halted_reg ? hstat_reg : ST_RUN;
                code_reg <= '0;
            end
            if (cmd.sys_ld)
            begin
                stat_reg <= ST_SYS;
                code_reg <= op_reg[5:0];
            end
            if (cmd.halt_ld)
            begin
                halted_reg <= 1'b1;
                hstat_reg  <= cmd.halt_code;
                hval_reg   <= cmd.halt_rd ? rdata_reg : 32'd0;
                stat_reg   <= cmd.halt_code;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_ld)
        begin
            inaddr_reg <= in_address;
            inval_reg  <= in_value;
        end
        if (cmd.op_ld)
        begin
            op_reg <= rdata_reg;
        end
        if (cmd.tmp_ld)
        begin
            tmp_reg <= rdata_reg;
        end
        if (cmd.out_ld)
        begin
            out_status <= stat_reg;
            out_pc     <= pc_reg;
            out_acc    <= acc_reg;
            out_sp     <= sp_reg;
            out_code   <= code_reg;
            out_exit   <= (stat_reg == ST_EXIT) ? hval_reg : 32'd0;
        end
    end

    assign stat.op       = op_reg[5:0];
    assign stat.op_known = (op_reg[31:6] == 26'd0) && (op_reg[5:0] <= OP_EXIT);
    assign stat.acc_zero = (acc_reg == 32'd0);
    assign stat.halted   = halted_reg;
    assign stat.div_busy = div_busy;
    assign stat.div_done = div_done;
endmodule

FILE: hdl/sbm_ctrl.sv
module sbm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    output logic               out_valid,
    input  logic               out_ready,
    input  sbm_pkg::sbm_stat_t stat,
    output sbm_pkg::sbm_cmd_t  cmd
);
    import sbm_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_WR     = 5'd1;
    localparam logic [4:0] S_SETACC = 5'd2;
    localparam logic [4:0] S_OP     = 5'd3;
    localparam logic [4:0] S_LATCH  = 5'd4;
    localparam logic [4:0] S_DEC    = 5'd5;
    localparam logic [4:0] S_IMM    = 5'd6;
    localparam logic [4:0] S_JMP    = 5'd7;
    localparam logic [4:0] S_LEV1   = 5'd8;
    localparam logic [4:0] S_LEV2   = 5'd9;
    localparam logic [4:0] S_LEV3   = 5'd10;
    localparam logic [4:0] S_LD     = 5'd11;
    localparam logic [4:0] S_POP    = 5'd12;
    localparam logic [4:0] S_ST     = 5'd13;
    localparam logic [4:0] S_SC     = 5'd14;
    localparam logic [4:0] S_EXIT   = 5'd15;
    localparam logic [4:0] S_BIN    = 5'd16;
    localparam logic [4:0] S_ALU    = 5'd17;
    localparam logic [4:0] S_DIV    = 5'd18;
    localparam logic [4:0] S_DONE   = 5'd19;

    logic [4:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_ld = 1'b1;
                    unique case (req_type)
                        REQ_WRITE:  state_next = S_WR;
                        REQ_EXEC:   state_next = stat.halted ? S_DONE : S_OP;
                        REQ_SETACC: state_next = S_SETACC;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_WR:
            begin
                cmd.addr_sel = ADDR_IN;
                cmd.wd_sel   = WD_IN;
                cmd.mem_we   = 1'b1;
                state_next   = S_DONE;
            end
            S_SETACC:
            begin
                cmd.acc_op = ACC_IN;
                state_next = S_DONE;
            end
            S_OP:
            begin
                cmd.addr_sel = ADDR_PC;
                cmd.pc_op    = PC_INC;
                state_next   = S_LATCH;
            end
            S_LATCH:
            begin
                cmd.op_ld  = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                state_next = S_DONE;
                if (!stat.op_known)
                begin
                    cmd.halt_ld   = 1'b1;
                    cmd.halt_code = ST_UNK;
                end
                else
                begin
                    unique case (stat.op) inside
                        OP_LEA, OP_IMM, OP_CALL, OP_JZ, OP_JNZ, OP_ENT, OP_ADJ:
                        begin
                            cmd.addr_sel = ADDR_PC;
                            cmd.pc_op    = PC_INC;
                            state_next   = S_IMM;
                        end
                        OP_JMP:
                        begin
                            cmd.addr_sel = ADDR_PC;
                            state_next   = S_JMP;
                        end
                        OP_LEV:
                        begin
                            cmd.addr_sel = ADDR_BP;
                            cmd.sp_op    = SP_BP;
                            state_next   = S_LEV1;
                        end
                        OP_LI, OP_LC:
                        begin
                            cmd.addr_sel = ADDR_ACC;
                            state_next   = S_LD;
                        end
                        OP_SI, OP_SC:
                        begin
                            cmd.addr_sel = ADDR_SP;
                            cmd.sp_op    = SP_INC;
                            state_next   = S_POP;
                        end
                        OP_PUSH:
                        begin
                            cmd.addr_sel = ADDR_SPM4;
                            cmd.wd_sel   = WD_ACC;
                            cmd.mem_we   = 1'b1;
                            cmd.sp_op    = SP_DEC;
                        end
                        [OP_OR:OP_MOD]:
                        begin
                            cmd.addr_sel = ADDR_SP;
                            state_next   = S_BIN;
                        end
                        [OP_SYS_FIRST:OP_SYS_LAST]:
                        begin
                            cmd.sys_ld = 1'b1;
                        end
                        OP_EXIT:
                        begin
                            cmd.addr_sel = ADDR_SP;
                            state_next   = S_EXIT;
                        end
                        default:
                        begin
                            cmd.halt_ld   = 1'b1;
                            cmd.halt_code = ST_UNK;
                        end
                    endcase
                end
            end
            S_IMM:
            begin
                state_next = S_DONE;
                case (stat.op)
                    OP_LEA:  cmd.acc_op = ACC_LEA;
                    OP_IMM:  cmd.acc_op = ACC_RD;
                    OP_CALL:
                    begin
                        cmd.addr_sel = ADDR_SPM4;
                        cmd.wd_sel   = WD_PC;
                        cmd.mem_we   = 1'b1;
                        cmd.sp_op    = SP_DEC;
                        cmd.pc_op    = PC_TGT;
                    end
                    OP_JZ:   cmd.pc_op = stat.acc_zero ? PC_TGT : PC_KEEP;
                    OP_JNZ:  cmd.pc_op = stat.acc_zero ? PC_KEEP : PC_TGT;
                    OP_ENT:
                    begin
                        cmd.addr_sel = ADDR_SPM4;
                        cmd.wd_sel   = WD_BP;
                        cmd.mem_we   = 1'b1;
                        cmd.bp_op    = BP_SPM4;
                        cmd.sp_op    = SP_ENT;
                    end
                    OP_ADJ:  cmd.sp_op = SP_ADJ;
                    default: cmd.acc_op = ACC_KEEP;
                endcase
            end
            S_JMP:
            begin
                cmd.pc_op  = PC_TGT;
                state_next = S_DONE;
            end
            S_LEV1:
            begin
                cmd.bp_op  = BP_RD;
                cmd.sp_op  = SP_INC;
                state_next = S_LEV2;
            end
            S_LEV2:
            begin
                cmd.addr_sel = ADDR_SP;
                cmd.sp_op    = SP_INC;
                state_next   = S_LEV3;
            end
            S_LEV3:
            begin
                cmd.pc_op  = PC_TGT;
                state_next = S_DONE;
            end
            S_LD:
            begin
                cmd.acc_op = (stat.op == OP_LC) ? ACC_BYTE : ACC_RD;
                state_next = S_DONE;
            end
            S_POP:
            begin
                cmd.tmp_ld = 1'b1;
                state_next = S_ST;
            end
            S_ST:
            begin
                cmd.addr_sel = ADDR_TMP;
                if (stat.op == OP_SI)
                begin
                    cmd.wd_sel = WD_ACC;
                    cmd.mem_we = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SC;
                end
            end
            S_SC:
            begin
                cmd.addr_sel = ADDR_TMP;
                cmd.wd_sel   = WD_BYTE;
                cmd.mem_we   = 1'b1;
                state_next   = S_DONE;
            end
            S_EXIT:
            begin
                cmd.halt_ld   = 1'b1;
                cmd.halt_code = ST_EXIT;
                cmd.halt_rd   = 1'b1;
                state_next    = S_DONE;
            end
            S_BIN:
            begin
                cmd.tmp_ld = 1'b1;
                state_next = S_ALU;
            end
            S_ALU:
            begin
                state_next = S_DONE;
                if (stat.op == OP_DIV || stat.op == OP_MOD)
                begin
                    if (stat.acc_zero)
                    begin
                        cmd.halt_ld   = 1'b1;
                        cmd.halt_code = ST_DIVZ;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else
                begin
                    cmd.acc_op = ACC_ALU;
                    cmd.sp_op  = SP_INC;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.acc_op = ACC_DIV;
                    cmd.sp_op  = SP_INC;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_ld     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

FILE: hdl/stack_bytecode_machine.sv
// Stack bytecode machine: one item per request writes a memory word, executes one
// instruction, or sets the accumulator (an execute while halted or an unknown request
// type does nothing), and each item yields one result item with the machine state.
// Everything goes through a single-port word memory, one access per cycle. DIV and
// MOD take the longest, because of the 32-step shift-subtract divider. A result that
// is not taken holds the block in its last state until it is. The result register
// lets the next item be accepted while a result waits.
`include "stack_bytecode_machine_macros.svh"

module stack_bytecode_machine (
    input  logic        clk,
    input  logic        rst_n,
    sbm_req_if.sink     req_ch,
    sbm_rsp_if.source   rsp_ch,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);
    import sbm_pkg::*;

    sbm_cmd_t  cmd;
    sbm_stat_t dp_stat;
    logic [31:0] acc_out;
    logic [31:0] exit_out;

    sbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_ch.valid),
        .in_ready  (req_ch.ready),
        .req_type  (req_ch.req_type),
        .out_valid (rsp_ch.valid),
        .out_ready (rsp_ch.ready),
        .stat      (dp_stat),
        .cmd       (cmd)
    );

    sbm_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (dp_stat),
        .in_address (req_ch.address),
        .in_value   ($unsigned(req_ch.value)),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .out_status (rsp_ch.status),
        .out_pc     (rsp_ch.pc_now),
        .out_acc    (acc_out),
        .out_sp     (rsp_ch.sp_now),
        .out_code   (rsp_ch.call_code),
        .out_exit   (exit_out)
    );

    assign rsp_ch.acc_now    = $signed(acc_out);
    assign rsp_ch.exit_value = $signed(exit_out);

    `SBM_ASSERT_NEXT(a_accept_leaves_idle, req_ch.valid && req_ch.ready, !req_ch.ready, "ready stayed high after an accepted item")
    `SBM_ASSERT_NOW(a_pc_aligned, rsp_ch.valid, rsp_ch.pc_now[1:0] == 2'b00, "program counter is not word aligned")
    `SBM_ASSERT_NOW(a_halt_sticky, 1'b1, !$fell(dp_stat.halted), "halted flag cleared without reset")
    `SBM_ASSERT_NOW(a_idle_div_quiet, req_ch.ready, !dp_stat.div_busy, "divider busy while waiting for an item")
    `SBM_ASSERT_NOW(a_call_code, rsp_ch.valid, (rsp_ch.status == ST_SYS) == (rsp_ch.call_code != 6'd0), "call code does not match status")
endmodule

FILE: tb/sv/tb_stack_bytecode_machine.sv
module tb_stack_bytecode_machine;
    import sbm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 60;
    localparam int FILL_OP = 0;
    localparam int FILL_IMM = 1;
    localparam int FILL_DATA = 2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] pc;
        logic [31:0] acc;
        logic [16:0] sp;
        logic [5:0]  code;
        logic [31:0] exitv;
    } state_rsp_t;

    typedef struct {
        logic [1:0]  rq;
        logic [15:0] ad;
        logic [31:0] v;
        bit          typed;
        state_rsp_t  want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_data = 16'd0;

    sbm_req_if req();
    sbm_rsp_if rsp();

    stack_bytecode_machine DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_ch(req),
        .rsp_ch(rsp),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Machine state as the block should hold it.
    logic [31:0] mem_img [MEM_WORDS];
    bit          mem_ok [MEM_WORDS];
    logic [15:0] vm_pc;
    logic [16:0] vm_sp;
    logic [16:0] vm_bp;
    logic [31:0] vm_acc;
    bit          vm_halted;
    logic [2:0]  vm_hstat;
    logic [31:0] vm_hval;

    state_rsp_t state_q[$];
    int errors = 0;
    int n_items = 0;
    int burst_left = 0;
    int unsigned cyc = 0;

    function automatic int unsigned widx(logic [31:0] a);
        return (a >> 2) % MEM_WORDS;
    endfunction

    function automatic logic [31:0] peek(logic [31:0] a);
        return mem_img[widx(a)];
    endfunction

    function automatic void poke(logic [31:0] a, logic [31:0] v);
        mem_img[widx(a)] = v;
        mem_ok[widx(a)] = 1'b1;
    endfunction

    function automatic logic [31:0] fetch_word();
        logic [31:0] w;
        w = peek(32'(vm_pc));
        vm_pc = vm_pc + 16'd4;
        return w;
    endfunction

    function automatic void push_word(logic [31:0] v);
        vm_sp = vm_sp - 17'd4;
        poke(32'(vm_sp), v);
    endfunction

    function automatic logic [31:0] pop_word();
        logic [31:0] w;
        w = peek(32'(vm_sp));
        vm_sp = vm_sp + 17'd4;
        return w;
    endfunction

    function automatic logic [15:0] jump_to(logic [31:0] w);
        return w[15:0] & 16'hFFFC;
    endfunction

    function automatic void halt_with(logic [2:0] st, logic [31:0] v);
        vm_halted = 1'b1;
        vm_hstat = st;
        vm_hval = v;
    endfunction

    function automatic logic [2:0] run_instr(output logic [5:0] code);
        logic [31:0] op;
        logic [31:0] imm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] w;
        logic [31:0] r;
        int sh;
        op = fetch_word();
        code = 6'd0;
        case (op)
            OP_LEA: begin imm = fetch_word(); vm_acc = {15'd0, vm_bp} + imm * 4; end
            OP_IMM: vm_acc = fetch_word();
            OP_JMP: vm_pc = jump_to(peek(32'(vm_pc)));
            OP_CALL:
            begin
                imm = fetch_word();
                push_word({16'd0, vm_pc});
                vm_pc = jump_to(imm);
            end
            OP_JZ: begin imm = fetch_word(); if (vm_acc == 0) vm_pc = jump_to(imm); end
            OP_JNZ: begin imm = fetch_word(); if (vm_acc != 0) vm_pc = jump_to(imm); end
            OP_ENT:
            begin
                imm = fetch_word();
                push_word({15'd0, vm_bp});
                vm_bp = vm_sp;
                vm_sp = vm_sp - 17'(imm * 4);
            end
            OP_ADJ: begin imm = fetch_word(); vm_sp = vm_sp + 17'(imm * 4); end
            OP_LEV:
            begin
                vm_sp = vm_bp;
                vm_bp = 17'(pop_word());
                vm_pc = jump_to(pop_word());
            end
            OP_LI: vm_acc = peek(vm_acc);
            OP_LC:
            begin
                b = (peek(vm_acc) >> (vm_acc[1:0] * 8)) & 32'hFF;
                vm_acc = {{24{b[7]}}, b[7:0]};
            end
            OP_SI: begin a = pop_word(); poke(a, vm_acc); end
            OP_SC:
            begin
                a = pop_word();
                sh = a[1:0] * 8;
                w = peek(a);
                w = (w & ~(32'hFF << sh)) | ((vm_acc & 32'hFF) << sh);
                poke(a, w);
            end
            OP_PUSH: push_word(vm_acc);
            OP_EXIT:
            begin
                halt_with(ST_EXIT, peek(32'(vm_sp)));
                return ST_EXIT;
            end
            default:
            begin
                if (op >= OP_OR && op <= OP_MOD)
                begin
                    a = peek(32'(vm_sp));
                    b = vm_acc;
                    case (op)
                        OP_OR: r = a | b;
                        OP_XOR: r = a ^ b;
                        OP_AND: r = a & b;
                        OP_EQ: r = {31'd0, a == b};
                        OP_NE: r = {31'd0, a != b};
                        OP_LT: r = {31'd0, $signed(a) < $signed(b)};
                        OP_GT: r = {31'd0, $signed(a) > $signed(b)};
                        OP_LE: r = {31'd0, $signed(a) <= $signed(b)};
                        OP_GE: r = {31'd0, $signed(a) >= $signed(b)};
                        OP_SHL: r = a << b[4:0];
                        OP_SHR: r = $signed(a) >>> b[4:0];
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = a * b;
                        default:
                        begin
                            if (b == 0)
                            begin
                                halt_with(ST_DIVZ, 32'd0);
                                return ST_DIVZ;
                            end
                            if (a == 32'h80000000 && b == 32'hFFFFFFFF)
                                r = (op == OP_DIV) ? 32'h80000000 : 32'd0;
                            else if (op == OP_DIV)
                                r = $signed(a) / $signed(b);
                            else
                                r = $signed(a) % $signed(b);
                        end
                    endcase
                    vm_sp = vm_sp + 17'd4;
                    vm_acc = r;
                end
                else if (op >= OP_SYS_FIRST && op <= OP_SYS_LAST)
                begin
                    code = op[5:0];
                    return ST_SYS;
                end
                else
                begin
                    halt_with(ST_UNK, 32'd0);
                    return ST_UNK;
                end
            end
        endcase
        return ST_RUN;
    endfunction

    function automatic state_rsp_t predict_state(logic [1:0] rq, logic [15:0] ad,
                                                 logic [31:0] v);
        state_rsp_t s;
        logic [2:0] st;
        logic [5:0] code;
        st = vm_halted ? vm_hstat : ST_RUN;
        code = 6'd0;
        if (rq == REQ_WRITE)
            poke({16'd0, ad}, v);
        else if (rq == REQ_EXEC)
        begin
            if (!vm_halted)
                st = run_instr(code);
        end
        else if (rq == REQ_SETACC)
            vm_acc = v;
        s.status = st;
        s.pc = vm_pc;
        s.acc = vm_acc;
        s.sp = vm_sp;
        s.code = code;
        s.exitv = (st == ST_EXIT) ? vm_hval : 32'd0;
        return s;
    endfunction

    // Finds the first word that the next instruction would read before it was written.
    function automatic bit find_hole(output logic [31:0] a, output int role);
        logic [31:0] op;
        logic [31:0] p1;
        role = FILL_DATA;
        a = {16'd0, vm_pc};
        if (!mem_ok[widx(a)]) begin role = FILL_OP; return 1'b1; end
        op = peek(32'(vm_pc));
        p1 = {16'd0, vm_pc + 16'd4};
        if (op <= OP_ADJ && op != OP_LEV)
        begin
            a = p1;
            role = FILL_IMM;
            return !mem_ok[widx(a)];
        end
        if (op == OP_LEV)
        begin
            a = {15'd0, vm_bp};
            if (!mem_ok[widx(a)]) return 1'b1;
            a = {15'd0, vm_bp + 17'd4};
            return !mem_ok[widx(a)];
        end
        if (op == OP_LI || op == OP_LC)
        begin
            a = vm_acc;
            return !mem_ok[widx(a)];
        end
        if (op == OP_SC)
        begin
            a = {15'd0, vm_sp};
            if (!mem_ok[widx(a)]) return 1'b1;
            a = peek(32'(vm_sp));
            return !mem_ok[widx(a)];
        end
        if (op == OP_SI || op == OP_EXIT || (op >= OP_OR && op <= OP_MOD))
        begin
            a = {15'd0, vm_sp};
            return !mem_ok[widx(a)];
        end
        return 1'b0;
    endfunction

    function automatic bit would_halt();
        logic [31:0] op;
        op = peek(32'(vm_pc));
        return op >= OP_EXIT || ((op == OP_DIV || op == OP_MOD) && vm_acc == 0);
    endfunction

    function automatic logic [31:0] pick_opcode();
        logic [31:0] op;
        do
            op = $urandom_range(0, 36);
        while (((op == OP_DIV || op == OP_MOD) && vm_acc == 0) ||
               (op >= OP_SYS_FIRST && $urandom_range(0, 2) != 0));
        return op;
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] op;
        op = peek(32'(vm_pc));
        if (op == OP_LEA || op == OP_ENT || op == OP_ADJ)
            return $urandom_range(0, 16) - 8;
        if (op == OP_IMM)
        begin
            case ($urandom_range(0, 5))
                0: return 32'h80000000;
                1: return 32'h7FFFFFFF;
                2: return 32'd0;
                3: return $urandom_range(0, 40) - 20;
                default: return $urandom;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_item(input logic [1:0] rq, input logic [15:0] ad, input logic [31:0] v,
                             input bit typed = 1'b0, input state_rsp_t want = '0);
        state_rsp_t p;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        p = predict_state(rq, ad, v);
        state_q.push_back(typed ? want : p);
        req.valid <= 1'b1;
        req.req_type <= rq;
        req.address <= ad;
        req.value <= v;
        do @(posedge clk); while (!req.ready);
        burst_left--;
        n_items++;
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        burst_left = 0;
        while (state_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_entry(input logic [15:0] v);
        wait_idle();
        cfg_data <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        vm_pc = v & 16'hFFFC;
        @(posedge clk);
    endtask

    // Fills every word the next instruction needs, then executes it.
    task automatic step_program();
        logic [31:0] a;
        int role;
        logic [31:0] v;
        forever
        begin
            if (find_hole(a, role))
            begin
                v = (role == FILL_OP) ? pick_opcode() :
                    (role == FILL_IMM) ? pick_operand() : $urandom;
                send_item(REQ_WRITE, a[15:0], v);
            end
            else if (would_halt())
                send_item(REQ_WRITE, vm_pc, pick_opcode());
            else
                break;
        end
        send_item(REQ_EXEC, 16'($urandom), $urandom);
        if (state_q.size() != 0 && state_q[$].status == ST_SYS && $urandom_range(0, 1))
            send_item(REQ_SETACC, 16'($urandom), $urandom);
    endtask

    task automatic run_random(input int upto);
        int r;
        while (n_items < upto)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                send_item(REQ_WRITE, 16'($urandom), $urandom);
            else if (r < 10)
                send_item(REQ_SETACC, 16'($urandom), $urandom);
            else if (r < 12)
                send_item(REQ_NONE, 16'($urandom), $urandom);
            else
                step_program();
        end
    endtask

    task automatic halt_machine();
        int kind;
        logic [31:0] op;
        kind = $urandom_range(0, 2);
        if (kind == 2)
            send_item(REQ_SETACC, 16'($urandom), 32'd0);
        if (!mem_ok[widx({15'd0, vm_sp})])
            send_item(REQ_WRITE, vm_sp[15:0], $urandom);
        if (kind == 0)
            op = 32'(OP_EXIT);
        else if (kind == 1)
            op = $urandom_range(0, 1) ? ($urandom | 32'h80000000) : $urandom_range(38, 1000);
        else
            op = $urandom_range(0, 1) ? 32'(OP_DIV) : 32'(OP_MOD);
        send_item(REQ_WRITE, vm_pc, op);
        send_item(REQ_EXEC, 16'd0, 32'd0);
        send_item(REQ_EXEC, 16'd0, 32'd0);
        send_item(REQ_WRITE, 16'($urandom), $urandom);
        send_item(REQ_SETACC, 16'($urandom), $urandom);
        send_item(REQ_NONE, 16'($urandom), $urandom);
        send_item(REQ_EXEC, 16'd0, 32'd0);
    endtask

    task automatic report(input string field, input logic [31:0] e, input logic [31:0] g);
        if (e !== g)
        begin
            $display("%0t mismatch in %s: expected %h, actual %h", $time, field, e, g);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        state_rsp_t e;
        int mode;
        if (rst_n)
        begin
            cyc++;
            if (rsp.valid && rsp.ready)
            begin
                if (state_q.size() == 0)
                begin
                    $display("%0t result with no expectation: status %h pc %h", $time,
                             rsp.status, rsp.pc_now);
                    errors++;
                end
                else
                begin
                    e = state_q.pop_front();
                    report("status", 32'(e.status), 32'(rsp.status));
                    report("pc_now", 32'(e.pc), 32'(rsp.pc_now));
                    report("acc_now", e.acc, rsp.acc_now);
                    report("sp_now", 32'(e.sp), 32'(rsp.sp_now));
                    report("call_code", 32'(e.code), 32'(rsp.call_code));
                    report("exit_value", e.exitv, rsp.exit_value);
                end
            end
            mode = (cyc >> 8) % 4;
            case (mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= 1'($urandom_range(0, 1));
                2: rsp.ready <= (cyc % 5 == 0);
                default: rsp.ready <= ($urandom_range(0, 7) != 0);
            endcase
            if (cyc > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        plan_row_t plan[$];
        state_rsp_t idle0;
        state_rsp_t t;
        logic [15:0] entries[5];

        req.valid = 1'b0;
        req.req_type = REQ_WRITE;
        req.address = 16'd0;
        req.value = 32'd0;
        rsp.ready = 1'b0;
        for (int i = 0; i < MEM_WORDS; i++)
        begin
            mem_img[i] = 32'd0;
            mem_ok[i] = 1'b0;
        end
        vm_pc = 16'd0;
        vm_sp = SP_TOP;
        vm_bp = SP_TOP;
        vm_acc = 32'd0;
        vm_halted = 1'b0;
        vm_hstat = ST_RUN;
        vm_hval = 32'd0;

        idle0 = '{ST_RUN, 16'd0, 32'd0, SP_TOP, 6'd0, 32'd0};
        plan.push_back('{REQ_WRITE, 16'd0, 32'(OP_IMM), 1'b1, idle0});
        plan.push_back('{REQ_WRITE, 16'd4, 32'h7FFFFFFF, 1'b1, idle0});
        t = '{ST_RUN, 16'd8, 32'h7FFFFFFF, SP_TOP, 6'd0, 32'd0};
        plan.push_back('{REQ_EXEC, 16'd0, 32'd0, 1'b1, t});
        plan.push_back('{REQ_WRITE, 16'd8, 32'(OP_PUSH), 1'b0, idle0});
        t = '{ST_RUN, 16'd12, 32'h7FFFFFFF, 17'd65532, 6'd0, 32'd0};
        plan.push_back('{REQ_EXEC, 16'd0, 32'd0, 1'b1, t});
        plan.push_back('{REQ_WRITE, 16'd12, 32'(OP_IMM), 1'b0, idle0});
        plan.push_back('{REQ_WRITE, 16'd16, 32'h80000000, 1'b0, idle0});
        t = '{ST_RUN, 16'd20, 32'h80000000, 17'd65532, 6'd0, 32'd0};
        plan.push_back('{REQ_EXEC, 16'hFFFF, 32'hFFFFFFFF, 1'b1, t});
        plan.push_back('{REQ_WRITE, 16'd20, 32'(OP_PUSH), 1'b0, idle0});
        plan.push_back('{REQ_EXEC, 16'd0, 32'd0, 1'b0, idle0});
        plan.push_back('{REQ_WRITE, 16'd24, 32'(OP_IMM), 1'b0, idle0});
        plan.push_back('{REQ_WRITE, 16'd28, 32'hFFFFFFFF, 1'b0, idle0});
        plan.push_back('{REQ_EXEC, 16'd0, 32'd0, 1'b0, idle0});
        plan.push_back('{REQ_WRITE, 16'd32, 32'(OP_DIV), 1'b0, idle0});
        plan.push_back('{REQ_EXEC, 16'd0, 32'd0, 1'b0, idle0});
        plan.push_back('{REQ_WRITE, 16'd36, 32'(OP_SYS_FIRST), 1'b0, idle0});
        t = '{ST_SYS, 16'd40, 32'h80000000, 17'd65532, OP_SYS_FIRST, 32'd0};
        plan.push_back('{REQ_EXEC, 16'd0, 32'd0, 1'b1, t});
        t = '{ST_RUN, 16'd40, 32'd0, 17'd65532, 6'd0, 32'd0};
        plan.push_back('{REQ_SETACC, 16'd0, 32'd0, 1'b1, t});
        plan.push_back('{REQ_NONE, 16'hFFFF, 32'hFFFFFFFF, 1'b0, idle0});
        plan.push_back('{REQ_WRITE, 16'd40, 32'(OP_SYS_LAST), 1'b0, idle0});
        plan.push_back('{REQ_EXEC, 16'd0, 32'd0, 1'b0, idle0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i].rq, plan[i].ad, plan[i].v, plan[i].typed, plan[i].want);

        entries[0] = 16'hFFFF;
        entries[1] = 16'h0000;
        entries[2] = 16'hFFFC;
        entries[3] = 16'($urandom);
        entries[4] = 16'($urandom) & 16'hFFFC;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_entry(entries[ph]);
            run_random(n_items + 130);
        end
        wait_idle();
        halt_machine();
        wait_idle();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
